// ===== sv/subnet_to_bin_classifier_assert.svh =====
// Assertion macros for the subnet-to-bin classifier.
`ifndef SUBNET_TO_BIN_CLASSIFIER_ASSERT_SVH
`define SUBNET_TO_BIN_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define STBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STBC_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define STBC_ASSERT(label, clk, rst, prop, msg)
`define STBC_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== sv/stbc_pkg.sv =====
// Shared types, codes and helpers of the subnet-to-bin classifier.
package stbc_pkg;

  localparam int ADDR_W  = 32;
  localparam int PLEN_W  = 6;
  localparam int BIN_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int ENTRY_W = ADDR_W + PLEN_W + BIN_W;

  localparam int DEF_MAX_PREFIXES = 16;
  localparam int DEF_MAX_INTERIOR = 16;

  localparam logic [FUNC_W-1:0] FN_ADD_PREFIX   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ADD_INTERIOR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP       = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CHECK        = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_len;
    logic [BIN_W-1:0]  bin_id;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] found_bin;
    logic             refused;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, clear scan and result
    logic append;    // write latched item into its store
    logic scan_e;    // walk the prefix table
    logic scan_i;    // walk the interior list
    logic cmp_bin;   // compare bin ids instead of masked addresses
    logic clr_scan;  // restart the scan index
    logic take_hit;  // record the current match
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic scan_done;
  } ctrl_sts_t;

  function automatic logic [PLEN_W-1:0] sat_plen(input logic [PLEN_W-1:0] plen);
    if (plen > PLEN_W'(ADDR_W)) begin
      return PLEN_W'(ADDR_W);
    end
    return plen;
  endfunction

  // plen is already saturated; a shift by the full width yields zero
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    if (plen == '0) begin
      return '0;
    end
    return ~({ADDR_W{1'b1}} >> plen);
  endfunction

endpackage

// ===== sv/stbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/stbc_ctrl.sv =====
// Controller state machine: sequences appends, table scans and the result beat.
module stbc_ctrl
  import stbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  ctrl_sts_t         sts,
  output ctrl_cmd_t         cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPEND = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_CHK_E  = 3'd3;
  localparam logic [2:0] ST_CHK_I  = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (func) inside
            FN_ADD_PREFIX, FN_ADD_INTERIOR: state_next = ST_APPEND;
            FN_LOOKUP:                      state_next = ST_LOOKUP;
            FN_CHECK:                       state_next = ST_CHK_E;
            default:                        state_next = ST_IDLE;
          endcase
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_RESP;
      end
      ST_LOOKUP: begin
        cmd.scan_e = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_RESP;
        end else if (sts.scan_done) begin
          state_next = ST_RESP;
        end
      end
      ST_CHK_E: begin
        cmd.scan_e  = 1'b1;
        cmd.cmp_bin = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_RESP;
        end else if (sts.scan_done) begin
          cmd.clr_scan = 1'b1;
          state_next   = ST_CHK_I;
        end
      end
      ST_CHK_I: begin
        cmd.scan_i  = 1'b1;
        cmd.cmp_bin = 1'b1;
        if (sts.match) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_RESP;
        end else if (sts.scan_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

`include "subnet_to_bin_classifier_assert.svh"

  `STBC_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `STBC_ASSERT(a_done_idle, clk, rst, done |=> !busy, "block stayed busy after result beat")
  `STBC_ASSERT(a_append_lat, clk, rst, (start && !busy && (func == FN_ADD_PREFIX || func == FN_ADD_INTERIOR)) |-> ##2 done, "append result not two cycles after accept")

endmodule

// ===== sv/stbc_dp.sv =====
// Datapath: item register, prefix and interior stores, scan index, compare and result.
module stbc_dp
  import stbc_pkg::*;
#(
  parameter int MAX_PREFIXES = DEF_MAX_PREFIXES,
  parameter int MAX_INTERIOR = DEF_MAX_INTERIOR
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output result_t   result
);

  localparam int IW_E = (MAX_PREFIXES > 1) ? $clog2(MAX_PREFIXES) : 1;
  localparam int IW_I = (MAX_INTERIOR > 1) ? $clog2(MAX_INTERIOR) : 1;
  localparam int CW_E = $clog2(MAX_PREFIXES + 1);
  localparam int CW_I = $clog2(MAX_INTERIOR + 1);
  localparam int SW   = (CW_E > CW_I) ? CW_E : CW_I;

  item_t            item_r;
  logic [CW_E-1:0]  ecount;
  logic [CW_I-1:0]  icount;
  logic [SW-1:0]    idx;
  logic             rd_vld;
  result_t          res;

  logic             efull;
  logic             ifull;
  logic [SW-1:0]    scan_cnt;
  logic             issue;
  logic             we_e;
  logic             we_i;
  logic [ENTRY_W-1:0] e_wdata;
  logic [ENTRY_W-1:0] e_rdata;
  logic [BIN_W-1:0] i_rdata;
  logic [ADDR_W-1:0] e_net;
  logic [PLEN_W-1:0] e_plen;
  logic [BIN_W-1:0] e_bin;
  logic [ADDR_W-1:0] e_mask;
  logic             match_e;
  logic             match_i;

  assign efull    = (ecount == CW_E'(MAX_PREFIXES));
  assign ifull    = (icount == CW_I'(MAX_INTERIOR));
  assign scan_cnt = cmd.scan_i ? SW'(icount) : SW'(ecount);
  assign issue    = (cmd.scan_e || cmd.scan_i) && (idx != scan_cnt);

  assign we_e    = cmd.append && (item_r.func == FN_ADD_PREFIX) && !efull;
  assign we_i    = cmd.append && (item_r.func == FN_ADD_INTERIOR) && !ifull;
  assign e_wdata = {item_r.address, item_r.prefix_len, item_r.bin_id};

  stbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PREFIXES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we_e),
    .waddr (ecount[IW_E-1:0]),
    .wdata (e_wdata),
    .raddr (idx[IW_E-1:0]),
    .rdata (e_rdata)
  );

  stbc_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_INTERIOR)
  ) u_interior_ram (
    .clk   (clk),
    .we    (we_i),
    .waddr (icount[IW_I-1:0]),
    .wdata (item_r.bin_id),
    .raddr (idx[IW_I-1:0]),
    .rdata (i_rdata)
  );

  assign {e_net, e_plen, e_bin} = e_rdata;
  assign e_mask  = prefix_mask(e_plen);
  assign match_e = cmd.cmp_bin ? (e_bin == item_r.bin_id)
                               : ((item_r.address & e_mask) == (e_net & e_mask));
  assign match_i = (i_rdata == item_r.bin_id);

  assign sts.match     = rd_vld && (cmd.scan_i ? match_i : match_e);
  assign sts.scan_done = (idx == scan_cnt) && !rd_vld;

  // item register; prefix length saturated once on capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= {item.func, item.address, sat_plen(item.prefix_len), item.bin_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= '0;
      icount <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we_e) begin
        ecount <= ecount + CW_E'(1);
      end
      if (we_i) begin
        icount <= icount + CW_I'(1);
      end
      if (cmd.load || cmd.clr_scan) begin
        idx    <= '0;
        rd_vld <= 1'b0;
      end else begin
        if (issue) begin
          idx <= idx + SW'(1);
        end
        rd_vld <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else if (cmd.load) begin
      res <= '0;
    end else begin
      if (cmd.append) begin
        res.refused <= (item_r.func == FN_ADD_PREFIX) ? efull : ifull;
      end
      if (cmd.take_hit) begin
        res.hit       <= 1'b1;
        res.found_bin <= cmd.cmp_bin ? '0 : e_bin;
      end
    end
  end

  assign result = res;

`include "subnet_to_bin_classifier_assert.svh"

  `STBC_ASSERT(a_ecount_max, clk, rst, ecount <= CW_E'(MAX_PREFIXES), "prefix count beyond capacity")
  `STBC_ASSERT(a_icount_max, clk, rst, icount <= CW_I'(MAX_INTERIOR), "interior count beyond capacity")
  `STBC_NEVER(a_hit_refused, clk, rst, res.hit && res.refused, "hit and refused in one result")

endmodule

// ===== sv/subnet_to_bin_classifier.sv =====
// Top level of the first-match IPv4 prefix classifier.
// Usage:
//   An item (func, address, prefix_len, bin_id) is taken at a clock edge with
//   start high and busy low. func selects: append a prefix entry, append an
//   interior bin id, classify an address, or check a bin id.
//   Each item gives one result beat: done is high for one cycle with result
//   (hit, found_bin, refused) valid; the receiver cannot stall it.
// Per function, accept to result beat:
//   lookup: scans the n stored prefix entries (at most MAX_PREFIXES) and
//           stops at the first match.
//   check:  reads the prefix table first, then the m interior ids (at most
//           MAX_INTERIOR); a match ends the scan early.
//   Each pass reads one entry per cycle through a single registered read port.
// Throughput: one item at a time; busy stays high through the result beat, so
//   no new item is taken until the result beat is over.
// Reset (synchronous, active high) empties both stores and returns to idle.
module subnet_to_bin_classifier
  import stbc_pkg::*;
#(
  parameter int MAX_PREFIXES = DEF_MAX_PREFIXES,
  parameter int MAX_INTERIOR = DEF_MAX_INTERIOR
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  stbc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  stbc_dp #(
    .MAX_PREFIXES (MAX_PREFIXES),
    .MAX_INTERIOR (MAX_INTERIOR)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule
